FILE: hw/rtl/sfp_pkg.sv
// shared types, codes and constants of the split-flap positioner
package sfp_pkg;

	// drum geometry and field widths
	localparam int FLAP_COUNT = 64;
	localparam int POS_W      = 6;
	localparam int TGT_W      = 8;
	localparam int DLY_W      = 16;
	localparam int PHASE_W    = 3;
	localparam int CFG_IDX_W  = 8;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_STOPPED  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SPINUP   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_HOMING   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_STEPPING = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SPINDOWN = 3'd4;

	// item kinds
	localparam logic OP_TICK       = 1'b0;
	localparam logic OP_SET_TARGET = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPINUP  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTOFF = 8'd1;

	// reset values of the delay registers
	localparam logic [DLY_W-1:0] SPINUP_RST  = 16'd100;
	localparam logic [DLY_W-1:0] SHUTOFF_RST = 16'd100;

	// one input word
	typedef struct packed {
		logic             op;
		logic [TGT_W-1:0] target_value;
		logic             home_sensor;
		logic             flap_sensor;
	} item_t;

	// one result word
	typedef struct packed {
		logic               done_res;
		logic               motor_drive;
		logic [POS_W-1:0]   position;
		logic [PHASE_W-1:0] phase;
	} result_t;

endpackage

FILE: hw/rtl/split_flap_positioner_unit.sv
// split-flap positioner top level: input stage, controller and output register
//
// Use: words enter on the s_ group. s_tuser is the kind: 0 is a tick carrying
// the home and flap sensor levels, 1 sets a new target flap. Every word gives
// exactly one result word on the m_ group with done, motor drive, the believed
// position and the phase after that word.
// Timing: a word accepted into the input stage is held there and processed
// when it moves on to the output register, whose load makes its result valid
// on m_; a stall on m_ can come in between. Throughput is one word per cycle
// while m_tready stays high; the whole step is a single pass of the phase logic
// between the input stage and the output register.
// Delay settings are written on the cfg_ channel (index 0 spin-up ticks,
// index 1 shut-off ticks; other indexes are ignored), always ready, and are
// meant to be changed only while no word is in flight.
// Reset: stopped, motor off, position and target 0, both delays 100 ticks,
// no word held.
// Stall: when m_tready is low the result is held; the input stage still takes
// one more word, and s_tready falls only while both stages are full.
module split_flap_positioner_unit
	import sfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,  // target_value[7:0], home_sensor[8], flap_sensor[9]
	input  logic                 s_tuser,  // op
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,  // done_res[0], motor_drive[1], position[7:2], phase[10:8]
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DLY_W-1:0]     cfg_data
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t result;
	logic    advance;
	logic    s_acc;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign s_acc     = s_tvalid && s_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1.op           <= s_tuser;
			item_s1.target_value <= s_tdata[7:0];
			item_s1.home_sensor  <= s_tdata[8];
			item_s1.flap_sensor  <= s_tdata[9];
		end
	end

	// phase controller
	sfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.go        (advance),
		.item      (item_s1),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.phase, out_q.position, out_q.motor_drive, out_q.done_res};

	// input side never blocks while the output register is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with output register empty");

	// a held word moves on whenever the output side can take it
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tready) |=> out_valid_q)
		else $error("held word not passed to output");

	// an accepted word always leaves a result in the output register or stays held in the input stage
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> ##1 (out_valid_q || valid_s1))
		else $error("accepted word lost");

endmodule

FILE: hw/rtl/sfp_ctrl.sv
// phase controller: state registers, delay settings and one-word step logic
module sfp_ctrl
	import sfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DLY_W-1:0]     cfg_data,
	input  logic                 go,
	input  item_t                item,
	output result_t              result
);

	logic [DLY_W-1:0]   spinup_q, shutoff_q;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [POS_W-1:0]   tgt_q, tgt_d;
	logic [DLY_W-1:0]   dly_q, dly_d;
	logic               last_flap_q, last_flap_d;
	logic               motor_q, motor_d;
	logic               done;

	logic               dly_end;
	logic [DLY_W-1:0]   dly_dec;
	logic [POS_W-1:0]   pos_inc;
	logic [POS_W-1:0]   tgt_red;
	logic               at_target;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spinup_q  <= SPINUP_RST;
			shutoff_q <= SHUTOFF_RST;
		end else if (cfg_wr) begin
			if (cfg_index == REG_SPINUP) begin
				spinup_q <= cfg_data;
			end else if (cfg_index == REG_SHUTOFF) begin
				shutoff_q <= cfg_data;
			end
		end
	end

	// helpers: delay countdown, flap increment with wrap, target reduction
	assign dly_end   = (dly_q <= DLY_W'(1));
	assign dly_dec   = dly_end ? '0 : dly_q - 1'b1;
	assign pos_inc   = (pos_q == POS_W'(FLAP_COUNT - 1)) ? '0 : pos_q + 1'b1;
	assign tgt_red   = POS_W'(item.target_value % FLAP_COUNT);
	assign at_target = (tgt_q == pos_q);

	// next state for the word in hand
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		tgt_d       = tgt_q;
		dly_d       = dly_q;
		last_flap_d = last_flap_q;
		motor_d     = motor_q;
		done        = 1'b0;
		if (item.op == OP_SET_TARGET) begin
			tgt_d = tgt_red;
			done  = (phase_q == PH_STOPPED) && (tgt_red == pos_q);
		end else begin
			unique case (phase_q)
				PH_SPINUP: begin
					dly_d = dly_dec;
					if (dly_end) begin
						phase_d = (tgt_q < pos_q) ? PH_HOMING : PH_STEPPING;
					end
				end
				PH_HOMING: begin
					if (!item.home_sensor) begin
						pos_d   = '0;
						motor_d = 1'b0;
						dly_d   = shutoff_q;
						phase_d = PH_SPINDOWN;
					end
				end
				PH_STEPPING: begin
					if (at_target) begin
						motor_d = 1'b0;
						dly_d   = shutoff_q;
						phase_d = PH_SPINDOWN;
					end else begin
						if (!last_flap_q && item.flap_sensor) begin
							pos_d = pos_inc;
						end
						last_flap_d = item.flap_sensor;
					end
				end
				PH_SPINDOWN: begin
					dly_d = dly_dec;
					if (dly_end) begin
						phase_d = PH_STOPPED;
					end
				end
				default: begin
					// stopped, and unused codes behave the same
					if (at_target) begin
						phase_d = PH_STOPPED;
						done    = 1'b1;
					end else begin
						motor_d = 1'b1;
						dly_d   = spinup_q;
						phase_d = PH_SPINUP;
					end
				end
			endcase
		end
	end

	// state registers, committed once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_STOPPED;
			pos_q       <= '0;
			tgt_q       <= '0;
			dly_q       <= '0;
			last_flap_q <= 1'b0;
			motor_q     <= 1'b0;
		end else if (go) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			tgt_q       <= tgt_d;
			dly_q       <= dly_d;
			last_flap_q <= last_flap_d;
			motor_q     <= motor_d;
		end
	end

	// result reflects the state after the word
	assign result.done_res    = done;
	assign result.motor_drive = motor_d;
	assign result.position    = pos_d;
	assign result.phase       = phase_d;

	// motor runs exactly in spin-up, homing and stepping
	a_motor_phase: assert property (@(posedge clk) disable iff (!arst_n)
		motor_q == (phase_q == PH_SPINUP || phase_q == PH_HOMING || phase_q == PH_STEPPING))
		else $error("motor state disagrees with phase");

	// a pending delay only exists while counting spin-up or spin-down
	a_delay_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(dly_q != '0) |-> (phase_q == PH_SPINUP || phase_q == PH_SPINDOWN))
		else $error("delay pending outside a delay phase");

	// position only moves while homing or stepping
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(go && phase_q != PH_HOMING && phase_q != PH_STEPPING) |=> $stable(pos_q))
		else $error("position moved outside homing or stepping");

	// done is only reported from the stopped phase
	a_done_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(go && done) |-> (phase_d == PH_STOPPED && pos_d == tgt_d))
		else $error("done reported while not settled");

endmodule
